// ===== src/ldbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear drag body motion package
// Number format, constants, saturation helpers and the types shared by the
// sequencer, the divider and the multiplier.
// ----------------------------------------------------------------------------
package ldbm_pkg;

    // Fixed-point format of every value.
    localparam int FRAC_BITS      = 16;
    localparam int EXP_TABLE_BITS = 8;
    localparam int LN_TAB_LEN     = 12;
    localparam int EXP_STEPS      = (EXP_TABLE_BITS < LN_TAB_LEN) ? EXP_TABLE_BITS : LN_TAB_LEN;
    localparam int LN_IDX_W       = $clog2(LN_TAB_LEN);

    // Divider numerator width: a 32-bit magnitude shifted up plus a carry bit.
    localparam int NUM_W = 33 + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    // Wide signed word for exact sums before saturation.
    localparam int WIDE_W = 68;
    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE_Q   = 32'(64'd1 << FRAC_BITS);
    localparam logic [31:0] GRAV_Y_RESET   = 32'(((64'd981 << FRAC_BITS) + 64'd50) / 64'd100);

    // ln(2) and ln(1 + 2^-i) in Q30.
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [29:0] LN_TAB [0:LN_TAB_LEN-1] = '{
        30'd435364845, 30'd239598564, 30'd126468572, 30'd65095192,
        30'd33040817,  30'd16647494,  30'd8356010,   30'd4186133,
        30'd2095107,   30'd1048064,   30'd524160,    30'd262112
    };

    // Range of the integer exponent that gives a finite, nonzero result.
    localparam longint N_LO   = 32 + FRAC_BITS;
    localparam longint N_HI   = 31 - FRAC_BITS;
    localparam longint EXP_HI = N_HI * 744261118;
    localparam longint EXP_LO = -(N_LO * 744261118);

    // The offset exponent argument stays below 64 * ln2, so the split on ln2
    // needs a 36-bit remainder and a 6-bit quotient.
    localparam int EXP_NUM_W = 36;
    localparam int EXP_Q_W   = 6;

    // Operation codes.
    localparam logic [1:0] OP_QUERY = 2'd0;
    localparam logic [1:0] OP_SPEED = 2'd1;
    localparam logic [1:0] OP_TELE  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAG    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_Y  = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE, S_DIV, S_DT, S_MULX, S_EXP0, S_EXPDIV, S_EXPLOOP, S_EXPCOR,
        S_EXPFIN, S_OME, S_TG, S_CE, S_TC, S_A1, S_A2, S_A3, S_POS, S_END
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [31:0]      den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic signed [32:0] a;
        logic signed [32:0] b;
    } t_mul_req;

    typedef struct packed {
        logic [65:0]        prod;
        logic signed [31:0] fx;
    } t_mul_rsp;

    // Clamp a wide signed value to 32 signed bits.
    function automatic logic signed [31:0] sat32(input t_wide v);
        if (v > t_wide'(S32_MAX)) return S32_MAX;
        if (v < t_wide'(S32_MIN)) return S32_MIN;
        return 32'(v);
    endfunction

    // Apply the sign to a quotient magnitude and clamp.
    function automatic logic signed [31:0] div_sat(input logic [NUM_W-1:0] q, input logic neg);
        t_wide w;
        w = t_wide'(q);
        return sat32(neg ? -w : w);
    endfunction

    function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

endpackage

// ===== src/ldbm_div.sv =====
// ----------------------------------------------------------------------------
// Linear drag body motion divider
// Restoring unsigned divider, one quotient bit per cycle, giving the floor
// quotient.
// ----------------------------------------------------------------------------
module ldbm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ldbm_pkg::t_div_req i_req,
    output ldbm_pkg::t_div_rsp o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [ldbm_pkg::CNT_W-1:0]     r_cnt;
    logic [31:0]                    r_rem;
    logic [31:0]                    r_den;
    logic [ldbm_pkg::NUM_W-1:0]     r_quo;
    logic [32:0]                    trial;
    logic                           fits;

    // Shift in the next numerator bit and try the subtraction.
    always_comb begin
        trial = {r_rem, r_quo[ldbm_pkg::NUM_W-1]};
        fits  = trial >= {1'b0, r_den};
    end

    // Control: busy flag, bit counter and the done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= ldbm_pkg::CNT_W'(ldbm_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ldbm_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.den;
            r_quo <= i_req.num;
        end else if (r_busy) begin
            r_rem <= fits ? 32'(trial - {1'b0, r_den}) : trial[31:0];
            r_quo <= {r_quo[ldbm_pkg::NUM_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ===== src/ldbm_mul.sv =====
// ----------------------------------------------------------------------------
// Linear drag body motion multiplier
// Registered signed multiply; gives the raw magnitude product and the
// fixed-point product rounded half away from zero and saturated.
// ----------------------------------------------------------------------------
module ldbm_mul (
    input  logic              i_clk,
    input  ldbm_pkg::t_mul_req i_req,
    output ldbm_pkg::t_mul_rsp o_rsp
);

    logic [32:0]       mag_a;
    logic [32:0]       mag_b;
    logic [65:0]       r_prod;
    logic              r_neg;
    logic [65:0]       rnd;
    ldbm_pkg::t_wide   val;

    // Operand magnitudes.
    always_comb begin
        mag_a = i_req.a[32] ? (~i_req.a + 33'd1) : i_req.a;
        mag_b = i_req.b[32] ? (~i_req.b + 33'd1) : i_req.b;
    end

    // Product register.
    always_ff @(posedge i_clk) begin
        r_prod <= mag_a * mag_b;
        r_neg  <= i_req.a[32] ^ i_req.b[32];
    end

    // Round at the binary point, restore the sign, clamp.
    always_comb begin
        rnd = (r_prod + (66'd1 << (ldbm_pkg::FRAC_BITS - 1))) >> ldbm_pkg::FRAC_BITS;
        val = r_neg ? -ldbm_pkg::t_wide'(rnd) : ldbm_pkg::t_wide'(rnd);
    end

    assign o_rsp.prod = r_prod;
    assign o_rsp.fx   = ldbm_pkg::sat32(val);

endmodule

// ===== src/linear_drag_body_motion.sv =====
// ----------------------------------------------------------------------------
// Linear drag body motion
// Closed-form 2D motion under gravity, a constant force and linear drag,
// evaluated by a sequencer around one shared divider and one multiplier.
// ----------------------------------------------------------------------------
// One request is taken at a time. Four divisions (mass/drag, drag/mass and
// force/drag per axis) run one after another on the bit-serial divider. One
// trajectory evaluation then follows: the exponent split on ln2 in six
// compare-and-subtract steps, eight shift-and-add steps of the exponential
// and fourteen multiplies on the shared multiplier. A query or teleport
// evaluates once and then loads its result; a set-speed request evaluates
// twice and loads its result after the second evaluation. The exponential
// steps are skipped when its argument saturates.
// A new request is accepted while a finished result still waits on the
// output; the block then waits in its last step until that result is taken.
module linear_drag_body_motion (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [95:0]                     s_tdata,   // when, val_x, val_y
    input  logic [1:0]                      s_tuser,   // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [127:0]                    m_tdata,   // pos_x, pos_y, vel_x, vel_y
    input  logic                            i_cfg_we,
    input  logic [ldbm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [31:0]                     i_cfg_data
);

    ldbm_pkg::t_state r_state, n_state;
    logic             r_ph, n_ph;
    logic             r_mvld;
    logic [127:0]     r_mdata;

    // Configuration and anchor.
    logic [31:0]        r_mass, r_drag;
    logic signed [31:0] r_force [2];
    logic signed [31:0] r_grav  [2];
    logic signed [31:0] r_apos  [2];
    logic signed [31:0] r_avel  [2];
    logic [31:0]        r_atime;

    // Request and working registers.
    logic [1:0]         r_op;
    logic [31:0]        r_when;
    logic signed [31:0] r_val [2];
    logic               r_pass;
    logic [1:0]         r_dsel;
    logic               r_ax;
    logic signed [31:0] r_tau, r_rate, r_dt, r_e, r_ome;
    logic signed [31:0] r_fk [2];
    logic signed [32:0] r_y;
    logic [ldbm_pkg::EXP_NUM_W-1:0] r_xr;
    logic [29:0]        r_rem;
    logic [ldbm_pkg::EXP_Q_W-1:0] r_q;
    logic [32:0]        r_m;
    logic [ldbm_pkg::LN_IDX_W-1:0] r_k;
    logic signed [31:0] r_tg, r_c, r_tc, r_disp;
    logic signed [33:0] r_acc;
    logic signed [31:0] r_rpos [2];
    logic signed [31:0] r_rvel [2];

    ldbm_pkg::t_div_req div_req;
    ldbm_pkg::t_div_rsp div_rsp;
    ldbm_pkg::t_mul_req mul_req;
    ldbm_pkg::t_mul_rsp mul_rsp;

    logic               accept;
    logic               out_load;
    logic               redo;
    logic [31:0]        m_eff, k_eff, fmag;
    logic signed [63:0] y30w;
    logic               exp_hi, exp_lo;
    logic [ldbm_pkg::EXP_NUM_W-1:0] xs, xnext;
    logic               xfit;
    logic [5:0]         sh;
    logic [63:0]        mw, mt;
    logic signed [31:0] exp_fin;

    ldbm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    ldbm_mul u_mul (
        .i_clk (i_clk),
        .i_req (mul_req),
        .o_rsp (mul_rsp)
    );

    assign s_tready = (r_state == ldbm_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = r_mvld;
    assign m_tdata  = r_mdata;
    assign redo     = (r_op == ldbm_pkg::OP_SPEED) && !r_pass;

    // Zero mass or drag counts as one LSB.
    always_comb begin
        m_eff = (r_mass == '0) ? 32'd1 : r_mass;
        k_eff = (r_drag == '0) ? 32'd1 : r_drag;
        fmag  = r_force[r_dsel[0]][31] ? (~r_force[r_dsel[0]] + 32'd1) : r_force[r_dsel[0]];
    end

    // Exponent split and final scaling of the exponential.
    always_comb begin
        y30w   = 64'(r_y) <<< (30 - ldbm_pkg::FRAC_BITS);
        exp_hi = y30w >= ldbm_pkg::EXP_HI;
        exp_lo = y30w < ldbm_pkg::EXP_LO;
        xs     = ldbm_pkg::EXP_NUM_W'(ldbm_pkg::LN2_Q30) << r_k;
        xfit   = r_xr >= xs;
        xnext  = xfit ? (r_xr - xs) : r_xr;
        sh     = 6'd62 - r_q;
        mw     = {31'b0, r_m};
        if (sh == 6'd0) begin
            mt = mw;
        end else begin
            mt = (mw + (64'd1 << (sh - 6'd1))) >> sh;
        end
        exp_fin = (mt > 64'h7FFF_FFFF) ? ldbm_pkg::S32_MAX : mt[31:0];
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ldbm_pkg::S_IDLE;
            r_ph    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
        end
    end

    // Sequencer: next state and the operands of the shared units.
    always_comb begin
        n_state       = r_state;
        n_ph          = r_ph;
        out_load      = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        div_req.start = 1'b0;
        div_req.den   = k_eff;
        unique case (r_dsel)
            2'd0:    div_req.num = {1'b0, m_eff, {ldbm_pkg::FRAC_BITS{1'b0}}}
                                   + ldbm_pkg::NUM_W'(k_eff >> 1);
            2'd1:    div_req.num = {1'b0, k_eff, {ldbm_pkg::FRAC_BITS{1'b0}}}
                                   + ldbm_pkg::NUM_W'(m_eff >> 1);
            default: div_req.num = {1'b0, fmag, {ldbm_pkg::FRAC_BITS{1'b0}}}
                                   + ldbm_pkg::NUM_W'(k_eff >> 1);
        endcase
        if (r_dsel == 2'd1) begin
            div_req.den = m_eff;
        end

        unique case (r_state)
            ldbm_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    n_state = ldbm_pkg::S_DIV;
                    n_ph    = 1'b0;
                end
            end
            ldbm_pkg::S_DIV: begin
                if (!r_ph) begin
                    div_req.start = 1'b1;
                    n_ph          = 1'b1;
                end else if (div_rsp.done) begin
                    n_ph = 1'b0;
                    if (r_dsel == 2'd3) begin
                        n_state = ldbm_pkg::S_DT;
                    end
                end
            end
            ldbm_pkg::S_DT: begin
                n_state = ldbm_pkg::S_MULX;
            end
            ldbm_pkg::S_MULX: begin
                mul_req.a = ldbm_pkg::sx33(r_rate);
                mul_req.b = ldbm_pkg::sx33(r_dt);
                n_ph      = !r_ph;
                if (r_ph) n_state = ldbm_pkg::S_EXP0;
            end
            ldbm_pkg::S_EXP0: begin
                if (exp_hi || exp_lo) begin
                    n_state = ldbm_pkg::S_OME;
                end else begin
                    n_state = ldbm_pkg::S_EXPDIV;
                end
            end
            ldbm_pkg::S_EXPDIV: begin
                if (r_k == '0) n_state = ldbm_pkg::S_EXPLOOP;
            end
            ldbm_pkg::S_EXPLOOP: begin
                if (r_k == ldbm_pkg::LN_IDX_W'(ldbm_pkg::EXP_STEPS - 1)) begin
                    n_state = ldbm_pkg::S_EXPCOR;
                end
            end
            ldbm_pkg::S_EXPCOR: begin
                mul_req.a = $signed(r_m);
                mul_req.b = $signed({3'b0, r_rem});
                n_ph      = !r_ph;
                if (r_ph) n_state = ldbm_pkg::S_EXPFIN;
            end
            ldbm_pkg::S_EXPFIN: begin
                n_state = ldbm_pkg::S_OME;
            end
            ldbm_pkg::S_OME: begin
                n_state = ldbm_pkg::S_TG;
            end
            ldbm_pkg::S_TG: begin
                mul_req.a = ldbm_pkg::sx33(r_tau);
                mul_req.b = ldbm_pkg::sx33(r_grav[r_ax]);
                n_ph      = !r_ph;
                if (r_ph) n_state = ldbm_pkg::S_CE;
            end
            ldbm_pkg::S_CE: begin
                mul_req.a = ldbm_pkg::sx33(r_c);
                mul_req.b = ldbm_pkg::sx33(r_e);
                n_ph      = !r_ph;
                if (r_ph) n_state = ldbm_pkg::S_TC;
            end
            ldbm_pkg::S_TC: begin
                mul_req.a = ldbm_pkg::sx33(r_tau);
                mul_req.b = ldbm_pkg::sx33(r_c);
                n_ph      = !r_ph;
                if (r_ph) n_state = ldbm_pkg::S_A1;
            end
            ldbm_pkg::S_A1: begin
                mul_req.a = ldbm_pkg::sx33(r_tc);
                mul_req.b = ldbm_pkg::sx33(r_ome);
                n_ph      = !r_ph;
                if (r_ph) n_state = ldbm_pkg::S_A2;
            end
            ldbm_pkg::S_A2: begin
                mul_req.a = ldbm_pkg::sx33(r_tg);
                mul_req.b = ldbm_pkg::sx33(r_dt);
                n_ph      = !r_ph;
                if (r_ph) n_state = ldbm_pkg::S_A3;
            end
            ldbm_pkg::S_A3: begin
                mul_req.a = ldbm_pkg::sx33(r_fk[r_ax]);
                mul_req.b = ldbm_pkg::sx33(r_dt);
                n_ph      = !r_ph;
                if (r_ph) n_state = ldbm_pkg::S_POS;
            end
            ldbm_pkg::S_POS: begin
                n_state = r_ax ? ldbm_pkg::S_END : ldbm_pkg::S_TG;
            end
            ldbm_pkg::S_END: begin
                if (redo) begin
                    n_state = ldbm_pkg::S_DT;
                end else if (!r_mvld || m_tready) begin
                    out_load = 1'b1;
                    n_state  = ldbm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ldbm_pkg::S_IDLE;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld <= 1'b0;
        end else if (out_load) begin
            r_mvld <= 1'b1;
        end else if (m_tready) begin
            r_mvld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_mdata <= {r_rvel[1], r_rvel[0], r_rpos[1], r_rpos[0]};
        end
    end

    // Configuration registers and the anchor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass     <= 32'(ldbm_pkg::ONE_Q);
            r_drag     <= 32'(ldbm_pkg::ONE_Q);
            r_force[0] <= '0;
            r_force[1] <= '0;
            r_grav[0]  <= '0;
            r_grav[1]  <= ldbm_pkg::GRAV_Y_RESET;
            r_apos[0]  <= '0;
            r_apos[1]  <= '0;
            r_avel[0]  <= '0;
            r_avel[1]  <= '0;
            r_atime    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ldbm_pkg::CFG_MASS:    r_mass     <= i_cfg_data;
                    ldbm_pkg::CFG_DRAG:    r_drag     <= i_cfg_data;
                    ldbm_pkg::CFG_FORCE_X: r_force[0] <= i_cfg_data;
                    ldbm_pkg::CFG_FORCE_Y: r_force[1] <= i_cfg_data;
                    ldbm_pkg::CFG_GRAV_X:  r_grav[0]  <= i_cfg_data;
                    ldbm_pkg::CFG_GRAV_Y:  r_grav[1]  <= i_cfg_data;
                    default: ;
                endcase
            end
            // Teleport moves the anchor before evaluation.
            if (accept && s_tuser == ldbm_pkg::OP_TELE) begin
                r_apos[0] <= s_tdata[63:32];
                r_apos[1] <= s_tdata[95:64];
                r_atime   <= s_tdata[31:0];
            end
            // Set-speed re-anchors on the trajectory, then evaluates again.
            if (r_state == ldbm_pkg::S_END && redo) begin
                r_apos[0] <= r_rpos[0];
                r_apos[1] <= r_rpos[1];
                r_avel[0] <= r_val[0];
                r_avel[1] <= r_val[1];
                r_atime   <= r_when;
            end
        end
    end

    // Working registers of the sequence.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= s_tuser;
            r_when   <= s_tdata[31:0];
            r_val[0] <= s_tdata[63:32];
            r_val[1] <= s_tdata[95:64];
            r_pass   <= 1'b0;
            r_dsel   <= '0;
        end
        unique case (r_state)
            ldbm_pkg::S_DIV: begin
                if (r_ph && div_rsp.done) begin
                    unique case (r_dsel)
                        2'd0:    r_tau <= ldbm_pkg::div_sat(div_rsp.quo, 1'b0);
                        2'd1:    r_rate <= ldbm_pkg::div_sat(div_rsp.quo, 1'b0);
                        default: r_fk[r_dsel[0]] <= ldbm_pkg::div_sat(div_rsp.quo,
                                                                      r_force[r_dsel[0]][31]);
                    endcase
                    r_dsel <= r_dsel + 2'd1;
                end
            end
            ldbm_pkg::S_DT: begin
                r_dt <= ldbm_pkg::sat32(ldbm_pkg::t_wide'({1'b0, r_when})
                                        - ldbm_pkg::t_wide'({1'b0, r_atime}));
            end
            ldbm_pkg::S_MULX: begin
                if (r_ph) r_y <= -ldbm_pkg::sx33(mul_rsp.fx);
            end
            // Saturated exponent, or load the offset argument for the split.
            ldbm_pkg::S_EXP0: begin
                if (exp_hi) begin
                    r_e <= ldbm_pkg::S32_MAX;
                end else if (exp_lo) begin
                    r_e <= '0;
                end else begin
                    r_xr <= ldbm_pkg::EXP_NUM_W'(y30w - ldbm_pkg::EXP_LO);
                    r_k  <= ldbm_pkg::LN_IDX_W'(ldbm_pkg::EXP_Q_W - 1);
                end
            end
            // One quotient bit of the split on ln2 per cycle, top bit first.
            ldbm_pkg::S_EXPDIV: begin
                r_xr <= xnext;
                r_q  <= {r_q[ldbm_pkg::EXP_Q_W-2:0], xfit};
                if (r_k == '0) begin
                    r_rem <= xnext[29:0];
                    r_m   <= 33'd1 << 30;
                end else begin
                    r_k <= r_k - 1'b1;
                end
            end
            // One shift-and-add step of exp(r) per cycle.
            ldbm_pkg::S_EXPLOOP: begin
                if (r_rem >= ldbm_pkg::LN_TAB[r_k]) begin
                    r_rem <= r_rem - ldbm_pkg::LN_TAB[r_k];
                    r_m   <= r_m + (r_m >> ({1'b0, r_k} + 1'b1));
                end
                r_k <= r_k + 1'b1;
            end
            ldbm_pkg::S_EXPCOR: begin
                if (r_ph) r_m <= r_m + 33'((mul_rsp.prod + (66'd1 << 29)) >> 30);
            end
            ldbm_pkg::S_EXPFIN: begin
                r_e <= exp_fin;
            end
            ldbm_pkg::S_OME: begin
                r_ome <= ldbm_pkg::ONE_Q - r_e;
                r_ax  <= 1'b0;
            end
            ldbm_pkg::S_TG: begin
                if (r_ph) begin
                    r_tg <= mul_rsp.fx;
                    r_c  <= ldbm_pkg::sat32(ldbm_pkg::t_wide'(mul_rsp.fx)
                                            + ldbm_pkg::t_wide'(r_avel[r_ax])
                                            - ldbm_pkg::t_wide'(r_fk[r_ax]));
                end
            end
            ldbm_pkg::S_CE: begin
                if (r_ph) begin
                    r_rvel[r_ax] <= ldbm_pkg::sat32(ldbm_pkg::t_wide'(mul_rsp.fx)
                                                    - ldbm_pkg::t_wide'(r_tg)
                                                    + ldbm_pkg::t_wide'(r_fk[r_ax]));
                end
            end
            ldbm_pkg::S_TC: begin
                if (r_ph) r_tc <= mul_rsp.fx;
            end
            ldbm_pkg::S_A1: begin
                if (r_ph) r_acc <= 34'(mul_rsp.fx);
            end
            ldbm_pkg::S_A2: begin
                if (r_ph) r_acc <= r_acc - 34'(mul_rsp.fx);
            end
            ldbm_pkg::S_A3: begin
                if (r_ph) begin
                    r_disp <= ldbm_pkg::sat32(ldbm_pkg::t_wide'(r_acc)
                                              + ldbm_pkg::t_wide'(mul_rsp.fx));
                end
            end
            ldbm_pkg::S_POS: begin
                r_rpos[r_ax] <= ldbm_pkg::sat32(ldbm_pkg::t_wide'(r_apos[r_ax])
                                                + ldbm_pkg::t_wide'(r_disp));
                r_ax <= 1'b1;
            end
            ldbm_pkg::S_END: begin
                if (redo) r_pass <= 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== src/ldbm_chk.sv =====
// ----------------------------------------------------------------------------
// Linear drag body motion checker
// Port-level checks of the request and result channels, bound to the top.
// ----------------------------------------------------------------------------
module ldbm_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [127:0]                   m_tdata
);

    // One request at a time: the input closes right after an acceptance.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while busy");

    // A stalled result holds its data.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // A result never appears the cycle after a request is accepted.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared too early");

endmodule

bind linear_drag_body_motion ldbm_chk u_ldbm_chk (.*);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Linear drag body motion testbench
// Drives query, set-speed and teleport requests with random gaps and
// output stalls, predicts every result from its own fixed-point model of
// the closed-form trajectory and checks each result field by field.
// ----------------------------------------------------------------------------

// Predicts results from the accepted requests and checks what arrives.
class motion_scoreboard;
    logic [31:0] mass, drag;
    logic signed [31:0] force_x, force_y, grav_x, grav_y;
    logic signed [31:0] apos_x, apos_y, avel_x, avel_y;
    logic [31:0] atime;
    logic [127:0] expected_q[$];
    int errors;

    function new();
        errors = 0;
        clear();
    endfunction

    function void clear();
        mass = 32'h10000;
        drag = 32'h10000;
        force_x = 0;
        force_y = 0;
        grav_x = 0;
        grav_y = ldbm_pkg::GRAV_Y_RESET;
        apos_x = 0;
        apos_y = 0;
        avel_x = 0;
        avel_y = 0;
        atime = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            ldbm_pkg::CFG_MASS:    mass = val;
            ldbm_pkg::CFG_DRAG:    drag = val;
            ldbm_pkg::CFG_FORCE_X: force_x = val;
            ldbm_pkg::CFG_FORCE_Y: force_y = val;
            ldbm_pkg::CFG_GRAV_X:  grav_x = val;
            ldbm_pkg::CFG_GRAV_Y:  grav_y = val;
            default: ;
        endcase
    endfunction

    function longint clamp(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function longint fmul(longint a, longint b);
        logic [63:0] p;
        longint r;
        p = (a < 0 ? -a : a) * (b < 0 ? -b : b);
        p = (p + 64'd32768) >> 16;
        r = longint'(p);
        return clamp(((a < 0) != (b < 0)) ? -r : r);
    endfunction

    function longint fdiv(longint a, longint b);
        logic [63:0] q, ma;
        if (b == 0) return a > 0 ? 64'sd2147483647 : (a < 0 ? -64'sd2147483648 : 0);
        ma = a < 0 ? -a : a;
        q = ((ma << 16) + b / 2) / b;
        return clamp(a < 0 ? -longint'(q) : longint'(q));
    endfunction

    // Exponential by range split on ln2 and shift-and-add over ln(1 + 2^-i).
    function longint fexp(longint y);
        longint y30, n, rem, s;
        logic [63:0] m;
        y30 = y * 16384;
        n = y30 / 744261118;
        if (y30 % 744261118 != 0 && y30 < 0) n--;
        rem = y30 - n * 744261118;
        m = 64'd1 << 30;
        for (int i = 1; i <= ldbm_pkg::EXP_STEPS; i++) begin
            if (rem >= longint'(ldbm_pkg::LN_TAB[i-1])) begin
                rem -= longint'(ldbm_pkg::LN_TAB[i-1]);
                m += m >> i;
            end
        end
        m += (m * rem + (64'd1 << 29)) >> 30;
        if (n >= 15) return 64'sd2147483647;
        s = 14 - n;
        if (s > 62) return 0;
        if (s > 0) m = (m + (64'd1 << (s - 1))) >> s;
        return m > 64'd2147483647 ? 64'sd2147483647 : longint'(m);
    endfunction

    function void one_axis(longint g, longint f, longint v0, longint p0, longint k,
                           longint tau, longint dt, longint e, longint ome,
                           output longint pos, output longint vel);
        longint tg, fk, c, disp;
        tg = fmul(tau, g);
        fk = fdiv(f, k);
        c = clamp(tg + v0 - fk);
        vel = clamp(fmul(c, e) - tg + fk);
        disp = clamp(fmul(fmul(tau, c), ome) - fmul(tg, dt) + fmul(fk, dt));
        pos = clamp(p0 + disp);
    endfunction

    function logic [127:0] trajectory_at(logic [31:0] t);
        longint m, k, tau, rate, dt, e, ome, px, py, vx, vy;
        m = mass != 0 ? longint'(mass) : 1;
        k = drag != 0 ? longint'(drag) : 1;
        tau = fdiv(m, k);
        rate = fdiv(k, m);
        dt = clamp(longint'(t) - longint'(atime));
        e = fexp(-fmul(rate, dt));
        ome = clamp(65536 - e);
        one_axis(grav_x, force_x, avel_x, apos_x, k, tau, dt, e, ome, px, vx);
        one_axis(grav_y, force_y, avel_y, apos_y, k, tau, dt, e, ome, py, vy);
        return {vy[31:0], vx[31:0], py[31:0], px[31:0]};
    endfunction

    // Note an accepted request: update the anchor and queue its result.
    function void note_request(logic [1:0] op, logic [31:0] t,
                               logic [31:0] vx, logic [31:0] vy);
        logic [127:0] r;
        if (op == ldbm_pkg::OP_SPEED) begin
            r = trajectory_at(t);
            apos_x = r[31:0];
            apos_y = r[63:32];
            atime = t;
            avel_x = vx;
            avel_y = vy;
        end else if (op == ldbm_pkg::OP_TELE) begin
            apos_x = vx;
            apos_y = vy;
            atime = t;
        end
        expected_q.push_back(trajectory_at(t));
    endfunction

    function void check_result(logic [127:0] got);
        logic [127:0] want;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        for (int f = 0; f < 4; f++) begin
            if (got[f*32 +: 32] !== want[f*32 +: 32]) begin
                $display("%0t: field %0d expected %h actual %h",
                         $time, f, want[f*32 +: 32], got[f*32 +: 32]);
                errors++;
            end
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 2_000_000;

    // Codes outside the defined sets: an unknown op is evaluated like a query, an unknown register index is ignored.
    localparam logic [1:0] OP_UNKNOWN  = 2'd3;
    localparam logic [2:0] CFG_UNKNOWN = 3'd7;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [31:0]  i_cfg_data = '0;

    motion_scoreboard board;
    int  cycles = 0;

    linear_drag_body_motion u_top (.*);

    always #1 i_clk = ~i_clk;

    // Cycle limit guards against a hung block.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Results are checked at the rising edge where they are taken.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    // The receiver stalls at random, mostly briefly.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 99) < 70) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 9) == 0) ? 1'b1 : 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 400);
    endfunction

    // Valid stays high into the next request when there is no gap.
    task automatic send_request(logic [1:0] op, logic [31:0] t,
                                logic [31:0] vx, logic [31:0] vy);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {vy, vx, t};
        do @(posedge i_clk); while (!s_tready);
        board.note_request(op, t, vx, vy);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        board.write_reg(idx, val);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (board.expected_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h000F_FFFF);
            3: return -$urandom_range(0, 32'h000F_FFFF);
            default: return $urandom;
        endcase
    endfunction

    // Random phase: mostly small forward time steps from the last anchor.
    task automatic random_phase(int count);
        logic [31:0] t;
        logic [1:0] op;
        t = board.atime;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0: t = $urandom;
                1: t = t - $urandom_range(0, 32'h3_0000);
                default: t = t + $urandom_range(0, 32'h4_0000);
            endcase
            op = $urandom_range(0, 3);
            send_request(op, t, rand_word(), rand_word());
        end
    endtask

    initial begin
        logic [31:0] masses[4] = '{32'h1, 32'h10000, 32'h28000, 32'hFFFF_FFFF};
        logic [31:0] drags[4]  = '{32'hFFFF_FFFF, 32'h10000, 32'h8000, 32'h1};
        board = new();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at the default settings.
        send_request(ldbm_pkg::OP_QUERY, 32'h0, 32'h0, 32'h0);
        send_request(ldbm_pkg::OP_QUERY, 32'h1_0000, 32'h0, 32'h0);
        send_request(ldbm_pkg::OP_SPEED, 32'h2_0000, 32'h5_0000, 32'h7FFF_FFFF);
        send_request(ldbm_pkg::OP_QUERY, 32'h3_8000, 32'h0, 32'h0);
        send_request(ldbm_pkg::OP_TELE, 32'h4_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(ldbm_pkg::OP_QUERY, 32'h1_0000, 32'h0, 32'h0);
        send_request(ldbm_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_UNKNOWN, 32'h5_0000, 32'h1234_5678, 32'h8765_4321);
        send_request(ldbm_pkg::OP_SPEED, 32'h0, 32'h8000_0000, 32'h8000_0000);
        send_request(ldbm_pkg::OP_TELE, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_request(ldbm_pkg::OP_QUERY, 32'h0, 32'h0, 32'h0);
        wait_idle();

        // Zero mass and drag fall back to one LSB.
        write_reg(ldbm_pkg::CFG_MASS, 32'h0);
        write_reg(ldbm_pkg::CFG_DRAG, 32'h0);
        write_reg(CFG_UNKNOWN, 32'hDEAD_BEEF);
        send_request(ldbm_pkg::OP_TELE, 32'h10, 32'h100, 32'h200);
        send_request(ldbm_pkg::OP_QUERY, 32'h1_0010, 32'h0, 32'h0);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(ldbm_pkg::CFG_MASS, ph < 4 ? masses[ph] : rand_word());
            write_reg(ldbm_pkg::CFG_DRAG, ph < 4 ? drags[ph] : rand_word());
            write_reg(ldbm_pkg::CFG_FORCE_X, ph == 1 ? 32'h8000_0000 : rand_word());
            write_reg(ldbm_pkg::CFG_FORCE_Y, ph == 1 ? 32'h7FFF_FFFF : rand_word());
            write_reg(ldbm_pkg::CFG_GRAV_X, ph == 2 ? 32'h7FFF_FFFF : rand_word());
            write_reg(ldbm_pkg::CFG_GRAV_Y, ph == 2 ? 32'h8000_0000 : rand_word());
            random_phase(170);
            wait_idle();
        end

        wait_idle();
        repeat (500) @(negedge i_clk);
        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
src/ldbm_pkg.sv
src/ldbm_div.sv
src/ldbm_mul.sv
src/linear_drag_body_motion.sv
src/ldbm_chk.sv
test/testbench.sv
